### design/snf_pkg.sv
// shared types, opcodes and helpers for the spi nor command framer
// no dependencies; used by every module of the framer
package snf_pkg;

  localparam int SNF_PAGE_BYTES      = 256;
  localparam int SNF_MAX_WRITE_BYTES = 4096;
  localparam int SNF_MAX_FRAMES      = 34;
  localparam int SNF_MAX_PAIRS       = SNF_MAX_FRAMES / 2;
  localparam int SNF_QDEPTH          = 2;

  // request codes as they arrive on the input channel
  localparam logic [3:0] CMD_READ   = 4'd0;
  localparam logic [3:0] CMD_FREAD  = 4'd1;
  localparam logic [3:0] CMD_WRITE  = 4'd2;
  localparam logic [3:0] CMD_SERASE = 4'd3;
  localparam logic [3:0] CMD_BERASE = 4'd4;
  localparam logic [3:0] CMD_CERASE = 4'd5;
  localparam logic [3:0] CMD_UNLOCK = 4'd6;
  localparam logic [3:0] CMD_RDSR1  = 4'd7;
  localparam logic [3:0] CMD_RDSR2  = 4'd8;
  localparam logic [3:0] CMD_RDSR3  = 4'd9;
  localparam logic [3:0] CMD_RDID   = 4'd10;
  localparam logic [3:0] CMD_WREN   = 4'd11;
  localparam logic [3:0] CMD_WRDI   = 4'd12;

  // flash opcodes
  localparam logic [7:0] OP_READ3   = 8'h03;
  localparam logic [7:0] OP_READ4   = 8'h13;
  localparam logic [7:0] OP_FREAD3  = 8'h0B;
  localparam logic [7:0] OP_FREAD4  = 8'h0C;
  localparam logic [7:0] OP_PP3     = 8'h02;
  localparam logic [7:0] OP_PP4     = 8'h12;
  localparam logic [7:0] OP_SE3     = 8'h20;
  localparam logic [7:0] OP_SE4     = 8'h21;
  localparam logic [7:0] OP_BE3     = 8'hD8;
  localparam logic [7:0] OP_BE4     = 8'hDC;
  localparam logic [7:0] OP_CE      = 8'hC7;
  localparam logic [7:0] OP_WRSR    = 8'h01;
  localparam logic [7:0] OP_RDSR1   = 8'h05;
  localparam logic [7:0] OP_RDSR2   = 8'h35;
  localparam logic [7:0] OP_RDSR3   = 8'h15;
  localparam logic [7:0] OP_RDID    = 8'h9F;
  localparam logic [7:0] OP_WREN    = 8'h06;
  localparam logic [7:0] OP_WRDI    = 8'h04;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_SEND = 2'd1;
  localparam logic [1:0] DIR_RECV = 2'd2;

  localparam logic [19:0] POLL_PP     = 20'd1000;
  localparam logic [19:0] POLL_SE     = 20'd1000;
  localparam logic [19:0] POLL_BE     = 20'd2000;
  localparam logic [19:0] POLL_CE     = 20'd600000;
  localparam logic [19:0] POLL_UNLOCK = 20'd100;

  // classified work item kinds
  typedef enum logic [3:0] {
    KIND_READ, KIND_FREAD, KIND_WRITE, KIND_WERR, KIND_SERASE, KIND_BERASE,
    KIND_CERASE, KIND_UNLOCK, KIND_RDSR1, KIND_RDSR2, KIND_RDSR3, KIND_RDID,
    KIND_WREN, KIND_WRDI
  } snf_kind_t;

  typedef struct packed {
    logic [3:0]  command;
    logic [31:0] address;
    logic [23:0] length;
  } snf_req_t;

  typedef struct packed {
    logic [7:0]  opcode;
    logic [31:0] frame_address;
    logic [2:0]  address_bytes;
    logic        dummy_bytes;
    logic [1:0]  data_direction;
    logic [23:0] data_bytes;
    logic [19:0] poll_timeout_ms;
    logic        error;
    logic        last;
  } snf_frame_t;

  typedef struct packed {
    snf_kind_t   kind;
    logic [31:0] address;
    logic [23:0] length;
  } snf_entry_t;

  // push side of the queue, front to queue
  typedef struct packed {
    logic       push;
    snf_entry_t entry;
  } snf_push_t;

  // pop side of the queue, queue to back end
  typedef struct packed {
    logic       not_empty;
    snf_entry_t entry;
  } snf_head_t;

  function automatic logic [7:0] snf_pick(input logic mode, input logic [7:0] op3,
                                          input logic [7:0] op4);
    return mode ? op4 : op3;
  endfunction

  function automatic logic [31:0] snf_addr(input logic mode, input logic [31:0] addr);
    return mode ? addr : {8'h00, addr[23:0]};
  endfunction

  function automatic logic [2:0] snf_abytes(input logic mode);
    return mode ? 3'd4 : 3'd3;
  endfunction

endpackage

### design/spi_nor_command_framer.sv
// spi nor command framer: request beats in, chip-select frame descriptor beats out
// a request reaches the queue at acceptance; the back end pops it and then registers its first frame
// frames of one request follow back to back while out_ready holds; the next item is popped only
//   after its last frame; for page sizes not a power of two a write first runs the offset fold, divide, subtract
// reset: rst_n synchronous active low; clears queue, sequencer, output valid and four_byte_mode
// depends on snf_pkg, snf_front, snf_queue, snf_back
module spi_nor_command_framer import snf_pkg::*; #(
  parameter int PAGE_BYTES      = SNF_PAGE_BYTES,
  parameter int MAX_WRITE_BYTES = SNF_MAX_WRITE_BYTES
) (
  input  logic       clk,
  input  logic       rst_n,
  // request channel
  input  logic       in_valid,
  output logic       in_ready,
  input  snf_req_t   in_data,
  // frame descriptor channel
  output logic       out_valid,
  input  logic       out_ready,
  output snf_frame_t out_data,
  // configuration register
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data
);

  logic      four_byte_mode_r;
  snf_push_t push;
  snf_head_t head;
  logic      q_full;
  logic      pop;

  // address mode register; the user must write it only while the framer is quiet, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      four_byte_mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      four_byte_mode_r <= cfg_wr_data;
    end
  end

  // front end: decode request, drop unused codes and empty writes, flag long writes
  snf_front #(
    .MAX_WRITE_BYTES (MAX_WRITE_BYTES)
  ) u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .push_o   (push)
  );

  // decoupling queue, lets the front keep taking beats while frames drain
  snf_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (push),
    .pop    (pop),
    .full   (q_full),
    .head_o (head)
  );

  // back end: frame sequencer with registered output beat
  snf_back #(
    .PAGE_BYTES      (PAGE_BYTES),
    .MAX_WRITE_BYTES (MAX_WRITE_BYTES)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .four_byte_mode (four_byte_mode_r),
    .head_i         (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data)
  );

endmodule

### design/snf_front.sv
// front end: takes request beats, classifies them and pushes work items
// depends on snf_pkg
module snf_front import snf_pkg::*; #(
  parameter int MAX_WRITE_BYTES = SNF_MAX_WRITE_BYTES
) (
  input  logic      in_valid,
  output logic      in_ready,
  input  snf_req_t  in_data,
  input  logic      q_full,
  output snf_push_t push_o
);

  logic      keep;
  snf_kind_t kind;

  assign in_ready = !q_full;

  always_comb begin
    keep = 1'b1;
    kind = KIND_READ;
    case (in_data.command)
      CMD_READ:   kind = KIND_READ;
      CMD_FREAD:  kind = KIND_FREAD;
      CMD_WRITE: begin
        if (in_data.length > 24'(MAX_WRITE_BYTES)) begin
          kind = KIND_WERR;
        end else begin
          kind = KIND_WRITE;
          // empty write gives no frames
          keep = (in_data.length != 24'd0);
        end
      end
      CMD_SERASE: kind = KIND_SERASE;
      CMD_BERASE: kind = KIND_BERASE;
      CMD_CERASE: kind = KIND_CERASE;
      CMD_UNLOCK: kind = KIND_UNLOCK;
      CMD_RDSR1:  kind = KIND_RDSR1;
      CMD_RDSR2:  kind = KIND_RDSR2;
      CMD_RDSR3:  kind = KIND_RDSR3;
      CMD_RDID:   kind = KIND_RDID;
      CMD_WREN:   kind = KIND_WREN;
      CMD_WRDI:   kind = KIND_WRDI;
      default:    keep = 1'b0;
    endcase
  end

  always_comb begin
    push_o.push          = in_valid && !q_full && keep;
    push_o.entry.kind    = kind;
    push_o.entry.address = in_data.address;
    push_o.entry.length  = in_data.length;
  end

endmodule

### design/snf_queue.sv
// short work item queue between front and back end
// depends on snf_pkg
module snf_queue import snf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  snf_push_t push_i,
  input  logic      pop,
  output logic      full,
  output snf_head_t head_o
);

  localparam int PTR_W = $clog2(SNF_QDEPTH);
  localparam int CNT_W = $clog2(SNF_QDEPTH + 1);

  snf_entry_t             mem_r [SNF_QDEPTH];
  logic [PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic                   do_pop;

  assign full   = (count_r == CNT_W'(SNF_QDEPTH));
  assign do_pop = pop && (count_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_i.push) begin
      wr_ptr_nxt = wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = rd_ptr_r + PTR_W'(1);
    end
    if (push_i.push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (!push_i.push && do_pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i.push) begin
      mem_r[wr_ptr_r] <= push_i.entry;
    end
  end

  always_comb begin
    head_o.not_empty = (count_r != '0);
    head_o.entry     = mem_r[rd_ptr_r];
  end

endmodule

### design/snf_back.sv
// back end: expands work items into frame descriptors, splits writes into pages
// depends on snf_pkg
module snf_back import snf_pkg::*; #(
  parameter int PAGE_BYTES      = SNF_PAGE_BYTES,
  parameter int MAX_WRITE_BYTES = SNF_MAX_WRITE_BYTES
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       four_byte_mode,
  input  snf_head_t  head_i,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output snf_frame_t out_data
);

  localparam int OFF_W  = $clog2(PAGE_BYTES);
  localparam int ROOM_W = $clog2(PAGE_BYTES + 1);
  localparam int REM_W  = $clog2(MAX_WRITE_BYTES + 1);
  localparam int CW     = (REM_W > ROOM_W) ? REM_W : ROOM_W;
  localparam int PAIR_W = $clog2(SNF_MAX_PAIRS + 1);
  localparam bit PAGE_POW2 = ((PAGE_BYTES & (PAGE_BYTES - 1)) == 0);
  localparam logic [63:0] P64    = 64'(PAGE_BYTES);
  // page offset reached after the address wraps past the top
  localparam logic [63:0] WRAP64 = (P64 - (64'h1_0000_0000 % P64)) % P64;
  // byte-wise fold of the address: weights of each byte modulo the page size
  localparam int FOLD_W = OFF_W + 10;
  localparam int RCP_K  = FOLD_W + OFF_W;
  localparam int PROD_W = 2 * FOLD_W + 1;
  localparam logic [FOLD_W-1:0] FOLD_C1 = FOLD_W'(64'h100 % P64);
  localparam logic [FOLD_W-1:0] FOLD_C2 = FOLD_W'(64'h1_0000 % P64);
  localparam logic [FOLD_W-1:0] FOLD_C3 = FOLD_W'(64'h100_0000 % P64);
  // reciprocal of the page size, exact quotient for any folded value
  localparam logic [FOLD_W:0]   RCP_M   = (FOLD_W + 1)'(((64'd1 << RCP_K) / P64) + 64'd1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MOD  = 4'b0010,
    ST_WREN = 4'b0100,
    ST_MAIN = 4'b1000
  } snf_state_t;

  snf_state_t        state_r, state_nxt;
  snf_kind_t         kind_r, kind_nxt;
  logic [31:0]       cur_r, cur_nxt;
  logic [23:0]       len_r, len_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [OFF_W-1:0]  off_r, off_nxt;
  logic [PAIR_W-1:0] pairs_r, pairs_nxt;
  logic [1:0]        step_r, step_nxt;
  logic [FOLD_W-1:0] fold_r, fold_nxt;
  logic [FOLD_W-1:0] quo_r, quo_nxt;
  logic              out_valid_r, out_valid_nxt;
  snf_frame_t        out_data_r, out_data_nxt;

  logic              emit_ok;
  logic [ROOM_W-1:0] room;
  logic [CW-1:0]     chunk;
  logic [32:0]       cur_sum;
  logic [REM_W-1:0]  rem_after;
  logic              write_last;
  logic [FOLD_W-1:0] fold_sum;
  logic [PROD_W-1:0] quo_prod;
  logic [FOLD_W-1:0] quo;
  logic [FOLD_W-1:0] off_calc;
  snf_frame_t        main_frame;
  snf_frame_t        wren_frame;

  assign emit_ok = !out_valid_r || out_ready;
  assign pop     = (state_r == ST_IDLE) && head_i.not_empty;

  // page chunk arithmetic
  always_comb begin
    room       = ROOM_W'(PAGE_BYTES) - ROOM_W'(off_r);
    chunk      = (CW'(rem_r) < CW'(room)) ? CW'(rem_r) : CW'(room);
    cur_sum    = {1'b0, cur_r} + 33'(chunk);
    rem_after  = rem_r - REM_W'(chunk);
    write_last = (rem_after == '0) || (pairs_r == PAIR_W'(SNF_MAX_PAIRS - 1));
  end

  // page offset for sizes that are not a power of two: fold, divide, subtract
  always_comb begin
    fold_sum = FOLD_W'(cur_r[31:24]) * FOLD_C3 + FOLD_W'(cur_r[23:16]) * FOLD_C2 +
               FOLD_W'(cur_r[15:8]) * FOLD_C1 + FOLD_W'(cur_r[7:0]);
    quo_prod = PROD_W'(fold_r) * PROD_W'(RCP_M);
    quo      = FOLD_W'(quo_prod >> RCP_K);
    off_calc = fold_r - quo_r * FOLD_W'(PAGE_BYTES);
  end

  always_comb begin
    wren_frame        = '0;
    wren_frame.opcode = OP_WREN;
  end

  always_comb begin
    main_frame = '0;
    main_frame.last = 1'b1;
    case (kind_r)
      KIND_READ: begin
        main_frame.opcode         = snf_pick(four_byte_mode, OP_READ3, OP_READ4);
        main_frame.frame_address  = snf_addr(four_byte_mode, cur_r);
        main_frame.address_bytes  = snf_abytes(four_byte_mode);
        main_frame.data_direction = DIR_RECV;
        main_frame.data_bytes     = len_r;
      end
      KIND_FREAD: begin
        main_frame.opcode         = snf_pick(four_byte_mode, OP_FREAD3, OP_FREAD4);
        main_frame.frame_address  = snf_addr(four_byte_mode, cur_r);
        main_frame.address_bytes  = snf_abytes(four_byte_mode);
        main_frame.dummy_bytes    = 1'b1;
        main_frame.data_direction = DIR_RECV;
        main_frame.data_bytes     = len_r;
      end
      KIND_WRITE: begin
        main_frame.opcode          = snf_pick(four_byte_mode, OP_PP3, OP_PP4);
        main_frame.frame_address   = snf_addr(four_byte_mode, cur_r);
        main_frame.address_bytes   = snf_abytes(four_byte_mode);
        main_frame.data_direction  = DIR_SEND;
        main_frame.data_bytes      = 24'(chunk);
        main_frame.poll_timeout_ms = POLL_PP;
        main_frame.last            = write_last;
      end
      KIND_WERR: begin
        main_frame.error = 1'b1;
      end
      KIND_SERASE: begin
        main_frame.opcode          = snf_pick(four_byte_mode, OP_SE3, OP_SE4);
        main_frame.frame_address   = snf_addr(four_byte_mode, cur_r);
        main_frame.address_bytes   = snf_abytes(four_byte_mode);
        main_frame.poll_timeout_ms = POLL_SE;
      end
      KIND_BERASE: begin
        main_frame.opcode          = snf_pick(four_byte_mode, OP_BE3, OP_BE4);
        main_frame.frame_address   = snf_addr(four_byte_mode, cur_r);
        main_frame.address_bytes   = snf_abytes(four_byte_mode);
        main_frame.poll_timeout_ms = POLL_BE;
      end
      KIND_CERASE: begin
        main_frame.opcode          = OP_CE;
        main_frame.poll_timeout_ms = POLL_CE;
      end
      KIND_UNLOCK: begin
        main_frame.opcode          = OP_WRSR;
        main_frame.data_direction  = DIR_SEND;
        main_frame.data_bytes      = 24'd2;
        main_frame.poll_timeout_ms = POLL_UNLOCK;
      end
      KIND_RDSR1: begin
        main_frame.opcode         = OP_RDSR1;
        main_frame.data_direction = DIR_RECV;
        main_frame.data_bytes     = 24'd1;
      end
      KIND_RDSR2: begin
        main_frame.opcode         = OP_RDSR2;
        main_frame.data_direction = DIR_RECV;
        main_frame.data_bytes     = 24'd1;
      end
      KIND_RDSR3: begin
        main_frame.opcode         = OP_RDSR3;
        main_frame.data_direction = DIR_RECV;
        main_frame.data_bytes     = 24'd1;
      end
      KIND_RDID: begin
        main_frame.opcode         = OP_RDID;
        main_frame.data_direction = DIR_RECV;
        main_frame.data_bytes     = 24'd3;
      end
      KIND_WREN: main_frame.opcode = OP_WREN;
      KIND_WRDI: main_frame.opcode = OP_WRDI;
      default:   main_frame = '0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    cur_nxt       = cur_r;
    len_nxt       = len_r;
    rem_nxt       = rem_r;
    off_nxt       = off_r;
    pairs_nxt     = pairs_r;
    step_nxt      = step_r;
    fold_nxt      = fold_r;
    quo_nxt       = quo_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (head_i.not_empty) begin
          kind_nxt  = head_i.entry.kind;
          cur_nxt   = head_i.entry.address;
          len_nxt   = head_i.entry.length;
          rem_nxt   = head_i.entry.length[REM_W-1:0];
          pairs_nxt = '0;
          case (head_i.entry.kind)
            KIND_WRITE: begin
              if (PAGE_POW2) begin
                off_nxt   = head_i.entry.address[OFF_W-1:0];
                state_nxt = ST_WREN;
              end else begin
                step_nxt  = 2'd0;
                state_nxt = ST_MOD;
              end
            end
            KIND_SERASE, KIND_BERASE, KIND_CERASE, KIND_UNLOCK: state_nxt = ST_WREN;
            default: state_nxt = ST_MAIN;
          endcase
        end
      end
      ST_MOD: begin
        step_nxt = step_r + 2'd1;
        if (step_r == 2'd0) begin
          fold_nxt = fold_sum;
        end else if (step_r == 2'd1) begin
          quo_nxt = quo;
        end else begin
          off_nxt   = off_calc[OFF_W-1:0];
          state_nxt = ST_WREN;
        end
      end
      ST_WREN: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = wren_frame;
          state_nxt     = ST_MAIN;
        end
      end
      ST_MAIN: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = main_frame;
          state_nxt     = ST_IDLE;
          if (kind_r == KIND_WRITE) begin
            cur_nxt   = cur_sum[31:0];
            rem_nxt   = rem_after;
            pairs_nxt = pairs_r + PAIR_W'(1);
            off_nxt   = cur_sum[32] ? WRAP64[OFF_W-1:0] : '0;
            if (!write_last) begin
              state_nxt = ST_WREN;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    cur_r      <= cur_nxt;
    len_r      <= len_nxt;
    rem_r      <= rem_nxt;
    off_r      <= off_nxt;
    pairs_r    <= pairs_nxt;
    step_r     <= step_nxt;
    fold_r     <= fold_nxt;
    quo_r      <= quo_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### test/spi_nor_command_framer_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for spi_nor_command_framer: directed table, then random phases
// depends on snf_pkg and the framer rtl; frames are predicted in-line and checked in order
module spi_nor_command_framer_tb;
  import snf_pkg::*;

  localparam int HALF_PERIOD      = 10;
  localparam int RESET_CYCLES     = 11;
  // let the framer pipeline settle before touching the mode bit
  localparam int SETTLE_CYCLES    = 8;
  localparam int DIRECTED_ROWS    = 25;
  localparam int RANDOM_PHASES    = 4;
  localparam int ITEMS_PER_PHASE  = 60;
  localparam int LONG_HOLD_CYCLES = 200;
  localparam int PAUSE_AT_ITEM    = 30;
  // request codes the framer ignores
  localparam logic [3:0] CMD_SPARE_FIRST = 4'd13;
  localparam logic [3:0] CMD_SPARE_LAST  = 4'd15;

  // one line of the directed table; typed rows carry their single frame verbatim
  typedef struct packed {
    logic       mode;
    snf_req_t   req;
    logic       typed;
    snf_frame_t frame;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  snf_req_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  snf_frame_t out_data;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_wr_data = 1'b0;

  // frames still owed by the framer, oldest first
  snf_frame_t pending_frames[$];
  // tb copy of the address mode register
  logic       four_byte = 1'b0;
  int         fails = 0;
  int         frames_checked = 0;
  int         requests_sent = 0;
  int         mode_writes = 0;
  // sender asks the receiver for one long hold-off
  bit         long_hold_req = 1'b0;

  spi_nor_command_framer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // build one descriptor; the address is cut to 24 bits unless in 4-byte mode
  function automatic snf_frame_t frame_of(input logic [7:0] op, input bit has_addr,
                                          input logic [31:0] addr, input logic wide,
                                          input logic dummy, input logic [1:0] dir,
                                          input logic [23:0] nbytes, input logic [19:0] poll);
    snf_frame_t f;
    f = '0;
    f.opcode = op;
    if (has_addr) begin
      f.frame_address = wide ? addr : (addr & 32'h00FF_FFFF);
      f.address_bytes = wide ? 3'd4 : 3'd3;
    end
    f.dummy_bytes     = dummy;
    f.data_direction  = dir;
    f.data_bytes      = nbytes;
    f.poll_timeout_ms = poll;
    return f;
  endfunction

  // expected frames of one request, appended to pending_frames
  function automatic void frame_request(input snf_req_t req, input logic wide);
    snf_frame_t  batch[$];
    snf_frame_t  f;
    int unsigned rem;
    int unsigned room;
    int unsigned chunk;
    logic [31:0] cur;
    case (req.command)
      CMD_READ: begin
        batch.push_back(frame_of(wide ? OP_READ4 : OP_READ3, 1, req.address, wide, 1'b0,
                                 DIR_RECV, req.length, 20'd0));
      end
      CMD_FREAD: begin
        batch.push_back(frame_of(wide ? OP_FREAD4 : OP_FREAD3, 1, req.address, wide, 1'b1,
                                 DIR_RECV, req.length, 20'd0));
      end
      CMD_WRITE: begin
        if (req.length > SNF_MAX_WRITE_BYTES) begin
          // rejected outright: one all-zero frame flagged as error
          f = '0;
          f.error = 1'b1;
          batch.push_back(f);
        end else begin
          // split at page boundaries, wren ahead of every page program
          rem = req.length;
          cur = req.address;
          while (rem > 0) begin
            room  = SNF_PAGE_BYTES - (cur % SNF_PAGE_BYTES);
            chunk = (rem < room) ? rem : room;
            batch.push_back(frame_of(OP_WREN, 0, '0, wide, 1'b0, DIR_NONE, '0, 20'd0));
            batch.push_back(frame_of(wide ? OP_PP4 : OP_PP3, 1, cur, wide, 1'b0, DIR_SEND,
                                     24'(chunk), POLL_PP));
            cur += chunk;
            rem -= chunk;
          end
        end
      end
      CMD_SERASE: begin
        batch.push_back(frame_of(OP_WREN, 0, '0, wide, 1'b0, DIR_NONE, '0, 20'd0));
        batch.push_back(frame_of(wide ? OP_SE4 : OP_SE3, 1, req.address, wide, 1'b0,
                                 DIR_NONE, '0, POLL_SE));
      end
      CMD_BERASE: begin
        batch.push_back(frame_of(OP_WREN, 0, '0, wide, 1'b0, DIR_NONE, '0, 20'd0));
        batch.push_back(frame_of(wide ? OP_BE4 : OP_BE3, 1, req.address, wide, 1'b0,
                                 DIR_NONE, '0, POLL_BE));
      end
      CMD_CERASE: begin
        batch.push_back(frame_of(OP_WREN, 0, '0, wide, 1'b0, DIR_NONE, '0, 20'd0));
        batch.push_back(frame_of(OP_CE, 0, '0, wide, 1'b0, DIR_NONE, '0, POLL_CE));
      end
      CMD_UNLOCK: begin
        // global unlock sends two bytes to the status register
        batch.push_back(frame_of(OP_WREN, 0, '0, wide, 1'b0, DIR_NONE, '0, 20'd0));
        batch.push_back(frame_of(OP_WRSR, 0, '0, wide, 1'b0, DIR_SEND, 24'd2, POLL_UNLOCK));
      end
      CMD_RDSR1: batch.push_back(frame_of(OP_RDSR1, 0, '0, wide, 1'b0, DIR_RECV, 24'd1, 20'd0));
      CMD_RDSR2: batch.push_back(frame_of(OP_RDSR2, 0, '0, wide, 1'b0, DIR_RECV, 24'd1, 20'd0));
      CMD_RDSR3: batch.push_back(frame_of(OP_RDSR3, 0, '0, wide, 1'b0, DIR_RECV, 24'd1, 20'd0));
      CMD_RDID:  batch.push_back(frame_of(OP_RDID, 0, '0, wide, 1'b0, DIR_RECV, 24'd3, 20'd0));
      CMD_WREN:  batch.push_back(frame_of(OP_WREN, 0, '0, wide, 1'b0, DIR_NONE, '0, 20'd0));
      CMD_WRDI:  batch.push_back(frame_of(OP_WRDI, 0, '0, wide, 1'b0, DIR_NONE, '0, 20'd0));
      default: begin
        // spare codes produce nothing
      end
    endcase
    if (batch.size() > 0) begin
      batch[batch.size() - 1].last = 1'b1;
    end
    foreach (batch[i]) begin
      pending_frames.push_back(batch[i]);
    end
  endfunction

  // directed table: field extremes, every command, both address modes, error and wrap cases
  function automatic stim_row_t directed_row(input int idx);
    stim_row_t r;
    r = '0;
    case (idx)
      0: begin
        // read of nothing at address zero, right after reset
        r.req   = '{CMD_READ, 32'h0000_0000, 24'h00_0000};
        r.typed = 1'b1;
        r.frame = '{OP_READ3, 32'h0, 3'd3, 1'b0, DIR_RECV, 24'h0, 20'd0, 1'b0, 1'b1};
      end
      1:  r.req = '{CMD_FREAD, 32'hFFFF_FFFF, 24'hFF_FFFF};
      2:  r.req = '{CMD_WRITE, 32'h0000_0000, 24'h00_0001};
      // largest legal write starting one byte before a page end: 17 pages
      3:  r.req = '{CMD_WRITE, 32'h0000_00FF, 24'(SNF_MAX_WRITE_BYTES)};
      4: begin
        // one byte over the write limit
        r.req   = '{CMD_WRITE, 32'h0001_0000, 24'(SNF_MAX_WRITE_BYTES + 1)};
        r.typed = 1'b1;
        r.frame = '{8'h00, 32'h0, 3'd0, 1'b0, DIR_NONE, 24'h0, 20'd0, 1'b1, 1'b1};
      end
      5: begin
        r.req   = '{CMD_WRITE, 32'hFFFF_FFFF, 24'hFF_FFFF};
        r.typed = 1'b1;
        r.frame = '{8'h00, 32'h0, 3'd0, 1'b0, DIR_NONE, 24'h0, 20'd0, 1'b1, 1'b1};
      end
      // zero-length write: no frames at all
      6:  r.req = '{CMD_WRITE, 32'h0000_1234, 24'h00_0000};
      7:  r.req = '{CMD_SERASE, 32'h00AB_CDEF, 24'h00_0000};
      8:  r.req = '{CMD_BERASE, 32'hFFFF_FFFF, 24'hFF_FFFF};
      9:  r.req = '{CMD_CERASE, 32'h0000_0000, 24'h00_0000};
      10: r.req = '{CMD_UNLOCK, 32'h5555_AAAA, 24'hAA_5555};
      11: begin
        r.req   = '{CMD_RDSR1, 32'h0, 24'h0};
        r.typed = 1'b1;
        r.frame = '{OP_RDSR1, 32'h0, 3'd0, 1'b0, DIR_RECV, 24'd1, 20'd0, 1'b0, 1'b1};
      end
      12: begin
        r.req   = '{CMD_RDSR2, 32'h0, 24'h0};
        r.typed = 1'b1;
        r.frame = '{OP_RDSR2, 32'h0, 3'd0, 1'b0, DIR_RECV, 24'd1, 20'd0, 1'b0, 1'b1};
      end
      13: begin
        r.req   = '{CMD_RDSR3, 32'hFFFF_FFFF, 24'hFF_FFFF};
        r.typed = 1'b1;
        r.frame = '{OP_RDSR3, 32'h0, 3'd0, 1'b0, DIR_RECV, 24'd1, 20'd0, 1'b0, 1'b1};
      end
      14: begin
        r.req   = '{CMD_RDID, 32'h0, 24'h0};
        r.typed = 1'b1;
        r.frame = '{OP_RDID, 32'h0, 3'd0, 1'b0, DIR_RECV, 24'd3, 20'd0, 1'b0, 1'b1};
      end
      15: begin
        r.req   = '{CMD_WREN, 32'h0, 24'h0};
        r.typed = 1'b1;
        r.frame = '{OP_WREN, 32'h0, 3'd0, 1'b0, DIR_NONE, 24'h0, 20'd0, 1'b0, 1'b1};
      end
      16: begin
        r.req   = '{CMD_WRDI, 32'h0, 24'h0};
        r.typed = 1'b1;
        r.frame = '{OP_WRDI, 32'h0, 3'd0, 1'b0, DIR_NONE, 24'h0, 20'd0, 1'b0, 1'b1};
      end
      17: r.req = '{CMD_SPARE_LAST, 32'hFFFF_FFFF, 24'hFF_FFFF};
      // four-byte address mode from here on
      18: begin
        r.mode = 1'b1;
        r.req  = '{CMD_READ, 32'hFFFF_FFFF, 24'h80_0000};
      end
      19: begin
        r.mode = 1'b1;
        r.req  = '{CMD_FREAD, 32'h1234_5678, 24'h00_0001};
      end
      20: begin
        // page split wraps past the top of the address space
        r.mode = 1'b1;
        r.req  = '{CMD_WRITE, 32'hFFFF_FFF0, 24'h00_0040};
      end
      21: begin
        r.mode = 1'b1;
        r.req  = '{CMD_WRITE, 32'h8000_0000, 24'(SNF_MAX_WRITE_BYTES)};
      end
      22: begin
        r.mode = 1'b1;
        r.req  = '{CMD_SERASE, 32'hFFFF_FFFF, 24'h00_0000};
      end
      23: begin
        r.mode = 1'b1;
        r.req  = '{CMD_BERASE, 32'h0000_0000, 24'h00_0000};
      end
      default: begin
        r.mode = 1'b1;
        r.req  = '{CMD_SPARE_FIRST, 32'h0000_0000, 24'h00_0000};
      end
    endcase
    return r;
  endfunction

  // random request: writes the most common code, the rest spread over all codes, addresses often near page edges
  function automatic snf_req_t random_request();
    snf_req_t r;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < 40)      r.command = CMD_WRITE;
    else if (pick < 48) r.command = CMD_READ;
    else if (pick < 55) r.command = CMD_FREAD;
    else if (pick < 62) r.command = CMD_SERASE;
    else if (pick < 68) r.command = CMD_BERASE;
    else if (pick < 71) r.command = CMD_CERASE;
    else if (pick < 75) r.command = CMD_UNLOCK;
    else if (pick < 95) r.command = 4'($urandom_range(CMD_RDSR1, CMD_WRDI));
    else                r.command = 4'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));

    r.address = $urandom;
    pick = $urandom_range(0, 9);
    if (pick >= 5 && pick < 8) begin
      // close to a page end so short writes still split
      r.address[7:0] = 8'($urandom_range(8'hE0, 8'hFF));
    end else if (pick == 8) begin
      r.address = 32'hFFFF_FF00 | 32'($urandom_range(0, 255));
    end else if (pick == 9) begin
      r.address = '0;
    end

    pick = $urandom_range(0, 99);
    if (r.command == CMD_WRITE) begin
      if (pick < 5)       r.length = '0;
      else if (pick < 60) r.length = 24'($urandom_range(1, 64));
      else if (pick < 80) r.length = 24'($urandom_range(65, 600));
      else if (pick < 88) r.length = 24'($urandom_range(601, SNF_MAX_WRITE_BYTES));
      else if (pick < 90) r.length = 24'(SNF_MAX_WRITE_BYTES);
      else if (pick < 95) r.length = 24'(SNF_MAX_WRITE_BYTES + 1);
      else                r.length = 24'($urandom_range(SNF_MAX_WRITE_BYTES + 1, 24'hFF_FFFF));
    end else begin
      r.length = (pick < 50) ? 24'($urandom_range(0, 300)) : 24'($urandom);
    end
    return r;
  endfunction

  function automatic int field_diff(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // sender gap: mostly none or short, now and then long
  task automatic idle_gap(input bit quiet);
    int g;
    int pick;
    pick = $urandom_range(0, 99);
    if (quiet || pick < 60) g = 0;
    else if (pick < 90)     g = $urandom_range(1, 3);
    else                    g = $urandom_range(8, 30);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // offer one request beat and hold it until taken, then queue its frames
  task automatic send_request(input snf_req_t req, input logic typed, input snf_frame_t tframe);
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (typed) pending_frames.push_back(tframe);
    else       frame_request(req, four_byte);
    if (req.command <= CMD_WRDI) requests_sent++;
  endtask

  // mode changes only with the framer drained and quiet
  task automatic set_mode(input logic mode);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    four_byte = mode;
    mode_writes++;
  endtask

  // result side: every frame beat is matched against the oldest expectation
  always @(posedge clk) begin
    snf_frame_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_frames.size() == 0) begin
        $error("unexpected frame beat: opcode %0h last %0b", out_data.opcode, out_data.last);
        fails++;
      end else begin
        want = pending_frames.pop_front();
        fails += field_diff("opcode", want.opcode, out_data.opcode);
        fails += field_diff("frame_address", want.frame_address, out_data.frame_address);
        fails += field_diff("address_bytes", want.address_bytes, out_data.address_bytes);
        fails += field_diff("dummy_bytes", want.dummy_bytes, out_data.dummy_bytes);
        fails += field_diff("data_direction", want.data_direction, out_data.data_direction);
        fails += field_diff("data_bytes", want.data_bytes, out_data.data_bytes);
        fails += field_diff("poll_timeout_ms", want.poll_timeout_ms, out_data.poll_timeout_ms);
        fails += field_diff("error", want.error, out_data.error);
        fails += field_diff("last", want.last, out_data.last);
        frames_checked++;
      end
    end
  end

  // receiver: random stalls, steady stretches, and one long hold-off on request
  initial begin
    int hold;
    int steady;
    int pick;
    hold   = 0;
    steady = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        // hold off long enough for the queue to fill and in_ready to drop
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end
      if (steady > 0) begin
        steady--;
        out_ready <= 1'b1;
      end else if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
          steady = $urandom_range(20, 80);
          out_ready <= 1'b1;
        end else if (pick < 20) begin
          hold = $urandom_range(0, 2);
          out_ready <= 1'b0;
        end else if (pick < 24) begin
          hold = $urandom_range(8, 30);
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
      @(posedge clk);
    end
  end

  // sender: reset, directed table, then random phases alternating the address mode
  initial begin
    stim_row_t row;
    snf_req_t  req;
    int        n;
    bit        quiet;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_mode(1'b0);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row = directed_row(i);
      if (row.mode !== four_byte) set_mode(row.mode);
      idle_gap(1'b0);
      send_request(row.req, row.typed, row.frame);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_mode(p[0]);
      // one phase runs back to back with no sender gaps
      quiet = (p == 2);
      // while the receiver sits on its hands, keep pushing beats
      if (p == 1) long_hold_req = 1'b1;
      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        if (n == PAUSE_AT_ITEM) begin
          // sender waits for every owed frame before going on
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending_frames.size() != 0) @(posedge clk);
        end
        req = random_request();
        idle_gap(quiet || (p == 1 && n < 20));
        send_request(req, 1'b0, '0);
        if (req.command <= CMD_WRDI) n++;
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    fails += pending_frames.size();

    $display("tb: %0d requests framed across %0d mode writes, %0d frame beats checked",
             requests_sent, mode_writes, frames_checked);
    $display("tb: covered every command, page-split and wrapped writes, write-limit errors");
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #(64'd30_000_000);
    $display("tb: failure");
    $finish;
  end

endmodule

### spi_nor_command_framer.f
design/snf_pkg.sv
design/snf_front.sv
design/snf_queue.sv
design/snf_back.sv
design/spi_nor_command_framer.sv
test/spi_nor_command_framer_tb.sv
